@@ rtl/fsp_pkg.sv @@
`timescale 1ns / 1ps

package fsp_pkg;

    // Pool geometry.
    localparam int MAX_SLOTS   = 256;
    localparam int ALIGN_BYTES = 16;
    localparam int LINK_BYTES  = 8;

    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int CNT_W    = SLOT_W + 1;
    localparam int OBJ_W    = 13;
    localparam int STRIDE_W = 14;
    localparam int OFFSET_W = 20;
    localparam int PROD_W   = SLOT_W + STRIDE_W;
    localparam int TOTAL_W  = 32;
    localparam int CFG_W    = 13;

    // Output item packing.
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 2;

    // End-of-list marker in the link memory and in the head pointer.
    localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(MAX_SLOTS);

    localparam logic [CNT_W-1:0] RESET_SLOT_COUNT = CNT_W'(MAX_SLOTS);
    localparam logic [OBJ_W-1:0] RESET_OBJECT_BYTES = OBJ_W'(LINK_BYTES);

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_POOL_EMPTY  = 2'd1,
        ST_BAD_FREE    = 2'd2,
        ST_NULL_FREE   = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    typedef enum logic {
        CFG_SLOT_COUNT   = 1'b0,
        CFG_OBJECT_BYTES = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    // Slot stride: object size raised to one link, rounded up to the alignment.
    function automatic logic [STRIDE_W-1:0] stride_of(input logic [OBJ_W-1:0] obj);
        logic [STRIDE_W:0] sz;
        logic [STRIDE_W:0] rounded;
        begin
            sz = (obj < OBJ_W'(LINK_BYTES)) ? (STRIDE_W+1)'(LINK_BYTES)
                                             : (STRIDE_W+1)'(obj);
            rounded = (STRIDE_W+1)'(((sz + (STRIDE_W+1)'(ALIGN_BYTES - 1)) / ALIGN_BYTES)
                                    * ALIGN_BYTES);
            stride_of = rounded[STRIDE_W-1:0];
        end
    endfunction

endpackage

@@ rtl/fixed_slot_pool_allocator.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Signals                        Contents (lowest bit first)
// s_axis    in         tvalid tready tdata tuser      tdata: slot_index; tuser: command, has_slot
// m_axis    out        tvalid tready tdata tuser      tdata: granted_slot, slot_offset,
//                                                     used_count, free_count, peak_used,
//                                                     alloc_total; tuser: status
// cfg       in         cfg_wr_en cfg_index cfg_data   0 slot_count, 1 object_bytes
//
// Each item is worked in turn: it is accepted while the link of the current head slot
// is read from the link memory, then the list is updated and the result register loaded.
// The successor of the head slot is known only in the cycle after its read, so the block
// takes no new item until the one before it has been worked.
// While a result waits on m_axis, the next item is still accepted; its update waits
// until the result register frees up. After reset the pool holds 256 slots chained in
// order with an 8-byte object size; the chain is held by per-slot valid bits, so no
// clearing pass is needed and items are taken from the first cycle.

module fixed_slot_pool_allocator
    import fsp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Input items.
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [SLOT_W-1:0]        s_axis_tdata,   // [7:0] slot_index
    input  logic [1:0]               s_axis_tuser,   // [0] command, [1] has_slot
    // Result items.
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_W-1:0]    m_axis_tdata,   // [7:0] granted_slot,
                                                     // [27:8] slot_offset,
                                                     // [36:28] used_count,
                                                     // [45:37] free_count,
                                                     // [54:46] peak_used,
                                                     // [86:55] alloc_total, [87] zero
    output logic [OUT_USER_W-1:0]    m_axis_tuser,   // [1:0] status
    // Configuration writes.
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    // Control and pool state.
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       slot_count_reg;
    logic [STRIDE_W-1:0]    stride_reg;
    logic [CNT_W-1:0]       head_reg;
    logic [CNT_W-1:0]       used_reg;
    logic [CNT_W-1:0]       peak_reg;
    logic [TOTAL_W-1:0]     total_reg;

    // A link entry that was never written since the last rebuild holds its chained
    // default; the valid bit tells the two apart.
    logic [MAX_SLOTS-1:0]   link_valid_reg;
    logic                   rd_valid_reg;
    logic [SLOT_W-1:0]      rd_addr_reg;

    // The item under work.
    logic                   cmd_reg;
    logic                   has_slot_reg;
    logic [SLOT_W-1:0]      idx_reg;

    // Result register.
    logic                   out_valid_reg;
    logic [OUT_USER_W-1:0]  out_status_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [OFFSET_W-1:0]    out_offset_reg;
    logic [CNT_W-1:0]       out_used_reg;
    logic [CNT_W-1:0]       out_free_reg;
    logic [CNT_W-1:0]       out_peak_reg;
    logic [TOTAL_W-1:0]     out_total_reg;

    logic                   in_accept;
    logic                   can_emit;
    logic                   do_exec;
    logic [CNT_W-1:0]       ram_rd_data;
    logic [CNT_W-1:0]       default_link;
    logic [CNT_W-1:0]       head_link;
    logic [CNT_W:0]         addr_plus_one;
    logic                   alloc_empty;
    logic                   free_bad;
    logic                   free_write;
    logic [PROD_W-1:0]      offset_prod;
    logic [CNT_W-1:0]       used_inc;
    logic [CNT_W-1:0]       used_dec;
    logic [CNT_W-1:0]       cfg_count;

    status_t                res_status;
    logic [SLOT_W-1:0]      res_slot;
    logic [OFFSET_W-1:0]    res_offset;
    logic [CNT_W-1:0]       res_used;
    logic [CNT_W-1:0]       res_peak;
    logic [TOTAL_W-1:0]     res_total;
    logic [CNT_W-1:0]       res_head;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign can_emit      = !out_valid_reg || m_axis_tready;
    assign do_exec       = (state_reg == S_EXEC) && can_emit;

    // A free writes a link only with a real slot inside the pool while something is allocated.
    assign free_bad   = ({1'b0, idx_reg} >= slot_count_reg) || (used_reg == '0);
    assign free_write = do_exec && (cmd_reg == CMD_FREE) && has_slot_reg && !free_bad;

    fsp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_SLOTS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (free_write),
        .wr_addr (idx_reg),
        .wr_data (head_reg),
        .rd_en   (in_accept),
        .rd_addr (head_reg[SLOT_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Successor of the head slot: the stored link if written since the rebuild,
    // else the next slot in order, or the end marker past the last slot.
    assign addr_plus_one = (CNT_W+1)'(rd_addr_reg) + (CNT_W+1)'(1);
    assign default_link  = (addr_plus_one < (CNT_W+1)'(slot_count_reg))
                           ? addr_plus_one[CNT_W-1:0] : NULL_LINK;
    assign head_link     = rd_valid_reg ? ram_rd_data : default_link;

    assign alloc_empty = (head_reg >= slot_count_reg) || (head_reg >= NULL_LINK) ||
                         (used_reg >= slot_count_reg);

    assign offset_prod = PROD_W'(head_reg[SLOT_W-1:0]) * PROD_W'(stride_reg);
    assign used_inc    = used_reg + CNT_W'(1);
    assign used_dec    = used_reg - CNT_W'(1);

    always_comb
    begin
        res_status = ST_OK;
        res_slot   = '0;
        res_offset = '0;
        res_used   = used_reg;
        res_peak   = peak_reg;
        res_total  = total_reg;
        res_head   = head_reg;
        unique case (cmd_reg)
            CMD_ALLOC:
            begin
                if (alloc_empty)
                begin
                    res_status = ST_POOL_EMPTY;
                end
                else
                begin
                    res_slot   = head_reg[SLOT_W-1:0];
                    res_offset = offset_prod[OFFSET_W-1:0];
                    res_used   = used_inc;
                    res_peak   = (used_inc > peak_reg) ? used_inc : peak_reg;
                    res_total  = total_reg + TOTAL_W'(1);
                    res_head   = head_link;
                end
            end
            CMD_FREE:
            begin
                if (!has_slot_reg)
                begin
                    res_status = ST_NULL_FREE;
                end
                else if (free_bad)
                begin
                    res_status = ST_BAD_FREE;
                end
                else
                begin
                    res_used = used_dec;
                    res_head = {1'b0, idx_reg};
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The slot count takes the low nine bits of cfg_data; zero means one, above the pool size is clamped.
    always_comb
    begin
        cfg_count = cfg_data[CNT_W-1:0];
        if (cfg_count == '0)
        begin
            cfg_count = CNT_W'(1);
        end
        else if (cfg_count > CNT_W'(MAX_SLOTS))
        begin
            cfg_count = CNT_W'(MAX_SLOTS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_count_reg <= RESET_SLOT_COUNT;
            stride_reg     <= stride_of(RESET_OBJECT_BYTES);
            head_reg       <= '0;
            used_reg       <= '0;
            peak_reg       <= '0;
            total_reg      <= '0;
            link_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // A new result takes the register in the same cycle the old one leaves.
            if (do_exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Configuration is to be written only while the block is idle, a rule on the user that
            // the block leaves unchecked. Writing the slot count rebuilds the list and clears the counters.
            if (cfg_wr_en && (cfg_index == CFG_SLOT_COUNT))
            begin
                slot_count_reg <= cfg_count;
                head_reg       <= '0;
                used_reg       <= '0;
                peak_reg       <= '0;
                total_reg      <= '0;
                link_valid_reg <= '0;
            end
            else
            begin
                if (do_exec)
                begin
                    head_reg  <= res_head;
                    used_reg  <= res_used;
                    peak_reg  <= res_peak;
                    total_reg <= res_total;
                end
                if (free_write)
                begin
                    link_valid_reg[idx_reg] <= 1'b1;
                end
            end

            if (cfg_wr_en && (cfg_index == CFG_OBJECT_BYTES))
            begin
                stride_reg <= stride_of(cfg_data[OBJ_W-1:0]);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg      <= s_axis_tuser[0];
            has_slot_reg <= s_axis_tuser[1];
            idx_reg      <= s_axis_tdata;
            rd_addr_reg  <= head_reg[SLOT_W-1:0];
            rd_valid_reg <= link_valid_reg[head_reg[SLOT_W-1:0]];
        end
        if (do_exec)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
            out_offset_reg <= res_offset;
            out_used_reg   <= res_used;
            out_free_reg   <= slot_count_reg - res_used;
            out_peak_reg   <= res_peak;
            out_total_reg  <= res_total;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {1'b0, out_total_reg, out_peak_reg, out_free_reg,
                            out_used_reg, out_offset_reg, out_slot_reg};

endmodule

@@ rtl/fsp_ram.sv @@
`timescale 1ns / 1ps

module fsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/fsp_checker.sv @@
`timescale 1ns / 1ps

module fsp_port_props
    import fsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [OUT_USER_W-1:0] m_axis_tuser
);

    logic [SLOT_W-1:0]   r_slot;
    logic [OFFSET_W-1:0] r_offset;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_free;
    logic [CNT_W-1:0]    r_peak;

    assign r_slot   = m_axis_tdata[7:0];
    assign r_offset = m_axis_tdata[27:8];
    assign r_used   = m_axis_tdata[36:28];
    assign r_free   = m_axis_tdata[45:37];
    assign r_peak   = m_axis_tdata[54:46];

    // One item is worked on at a time: the cycle after an accept is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item was still in work");

    // In-use and available slots never exceed the pool, and the peak covers the use.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((10'(r_used) + 10'(r_free)) <= 10'(MAX_SLOTS)) &&
                          (r_peak >= r_used))
        else $error("result counts out of range");

    // Only a granted alloc carries a slot and an offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (r_slot == '0) && (r_offset == '0))
        else $error("slot or offset given on a failed item");

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result withdrawn or changed while stalled");

endmodule

bind fixed_slot_pool_allocator fsp_port_props u_fsp_port_props (.*);
